/* hdl/scs_pkg.sv */
// ----------------------------------------------------------------------------
// scs_pkg: shared types, constants and functions for the sphere center solver
// Sizes of the stores, command and status bundles, saturating helpers.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int MAX_DIM   = 16;
	localparam int ROW_LEN   = MAX_DIM + 1;
	localparam int DEPTH     = (MAX_DIM + 1) * MAX_DIM;
	localparam int AW        = $clog2(DEPTH);
	localparam int IDX_W     = $clog2(MAX_DIM + 2);
	localparam int DIM_W     = 5;
	localparam int COORD_W   = 24;
	localparam int VAL_W     = 64;
	localparam int DIV_STEPS = 88;
	localparam int COEF_SHIFT = 17;
	localparam int RHS_SHIFT  = 8;
	localparam int FRAC_BITS  = 24;

	localparam logic [VAL_W-1:0] S_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] S_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// matrix write data source
	typedef enum logic [2:0] {
		WSEL_COEF,
		WSEL_RHS,
		WSEL_RD_A,
		WSEL_RD_B,
		WSEL_SUB,
		WSEL_ACC
	} wsel_t;

	// operand sources of the shared arithmetic units
	typedef enum logic {
		SRC_ELIM,
		SRC_BACK
	} src_t;

	typedef struct packed {
		logic             ps_we;
		logic [AW-1:0]    ps_waddr;
		logic             ps_re;
		logic [AW-1:0]    ps_raddr;
		logic             b_cap;
		logic             bld_diff;
		logic             bld_mul;
		logic             rhs_clr;
		logic             rhs_acc;
		logic             mat_re;
		logic [AW-1:0]    mat_raddr_a;
		logic [AW-1:0]    mat_raddr_b;
		logic             mat_we;
		logic [AW-1:0]    mat_waddr;
		wsel_t            mat_wsel;
		logic             div_start;
		src_t             div_src;
		logic             mul_start;
		src_t             mul_src;
		logic             acc_load;
		logic             acc_sub;
		logic             acc_div;
		logic             acc_zero;
		logic             out_load;
		logic             out_last;
		logic             out_sing;
	} scs_cmd_t;

	typedef struct packed {
		logic rd_a_zero;
		logic mul_done;
		logic div_done;
	} scs_sts_t;

	function automatic logic [VAL_W-1:0] mag64(input logic [VAL_W-1:0] v);
		return v[VAL_W-1] ? (~v + 1'b1) : v;
	endfunction

	// clamp a magnitude with sign into the signed 64-bit range
	function automatic logic [VAL_W-1:0] sat64(input logic [VAL_W-1:0] mag,
		input logic neg, input logic ovf);
		logic [VAL_W-1:0] r;
		if (neg) begin
			if (ovf || mag > S_MIN) r = S_MIN;
			else r = ~mag + 1'b1;
		end else begin
			if (ovf || mag > S_MAX) r = S_MAX;
			else r = mag;
		end
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] sat_sub64(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] r;
		r = a - b;
		if ((a[VAL_W-1] != b[VAL_W-1]) && (r[VAL_W-1] != a[VAL_W-1]))
			r = a[VAL_W-1] ? S_MIN : S_MAX;
		return r;
	endfunction

	function automatic logic [AW-1:0] mat_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		return AW'(32'(r) * ROW_LEN + 32'(c));
	endfunction

endpackage

/* hdl/scs_if.sv */
// ----------------------------------------------------------------------------
// scs channel interfaces
// Valid/ready channels for input coordinates and result center coordinates.
// ----------------------------------------------------------------------------
interface scs_coord_if import scs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] coordinate;

	modport source(output valid, output coordinate, input ready);
	modport sink(input valid, input coordinate, output ready);
endinterface

interface scs_center_if import scs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] center_coordinate;
	logic                    last_coordinate;
	logic                    singular;

	modport source(output valid, output center_coordinate, output last_coordinate,
		output singular, input ready);
	modport sink(input valid, input center_coordinate, input last_coordinate,
		input singular, output ready);
endinterface

/* hdl/sphere_center_linear_solver_top.sv */
// ----------------------------------------------------------------------------
// sphere_center_linear_solver_top: sphere center from dimension+1 points
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Loads (n+1)*n Q16.8 coordinates at one word per cycle, then builds the
// n-by-n system, solves it by Gaussian elimination with first-nonzero pivot
// and back substitution, and returns n Q40.24 center words, the last marked.
// After the final load word, about n*n*n/3 products (four partial products
// and a saturate step plus memory read, start and write-back) and about n*n/2
// divisions (88-step bit-serial divider), with the system build and row swaps,
// set the run time; the single-write matrix memory serializes every update.
// Input is not accepted while a run is solving or emitting. Writing cfg_wdata
// sets the dimension (0 acts as 1, above 16 as 16) and drops any partial load.
// ----------------------------------------------------------------------------
module sphere_center_linear_solver_top import scs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DIM_W-1:0] cfg_wdata,
	scs_coord_if.sink        coords,
	scs_center_if.source     centers
);

	scs_cmd_t cmd;
	scs_sts_t sts;

	scs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (coords.valid),
		.in_ready (coords.ready),
		.out_valid(centers.valid),
		.out_ready(centers.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	scs_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.coordinate       (coords.coordinate),
		.center_coordinate(centers.center_coordinate),
		.last_coordinate  (centers.last_coordinate),
		.singular         (centers.singular)
	);

endmodule

/* hdl/scs_mul.sv */
// ----------------------------------------------------------------------------
// scs_mul: Q40.24 saturating multiplier
// Four 32x32 partial products in sequence, then scale and saturate.
// ----------------------------------------------------------------------------
module scs_mul import scs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] a,
	input  logic [VAL_W-1:0] b,
	output logic             done,
	output logic [VAL_W-1:0] res
);

	localparam int HW = VAL_W / 2;

	typedef enum logic [1:0] {
		M_IDLE,
		M_RUN,
		M_FIN
	} mstate_t;

	mstate_t            state_q;
	logic [1:0]         cnt_q;
	logic [VAL_W-1:0]   ma_q;
	logic [VAL_W-1:0]   mb_q;
	logic               neg_q;
	logic [2*VAL_W-1:0] acc_q;
	logic [VAL_W-1:0]   res_q;
	logic               done_q;
	logic [HW-1:0]      op_a;
	logic [HW-1:0]      op_b;
	logic [VAL_W-1:0]   part;
	logic [2*VAL_W-1:0] part_sh;

	// pick halves for this partial product
	always_comb begin
		op_a    = cnt_q[1] ? ma_q[VAL_W-1:HW] : ma_q[HW-1:0];
		op_b    = cnt_q[0] ? mb_q[VAL_W-1:HW] : mb_q[HW-1:0];
		part    = VAL_W'(op_a) * VAL_W'(op_b);
		part_sh = (2*VAL_W)'(part) << (HW * (32'(cnt_q[1]) + 32'(cnt_q[0])));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						ma_q    <= mag64(a);
						mb_q    <= mag64(b);
						neg_q   <= a[VAL_W-1] ^ b[VAL_W-1];
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					acc_q <= acc_q + part_sh;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) state_q <= M_FIN;
				end
				M_FIN: begin
					res_q   <= sat64(acc_q[VAL_W+FRAC_BITS-1:FRAC_BITS], neg_q,
						|acc_q[2*VAL_W-1:VAL_W+FRAC_BITS]);
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* hdl/scs_div.sv */
// ----------------------------------------------------------------------------
// scs_div: Q40.24 saturating divider
// Restoring division, one quotient bit per cycle, then saturate.
// ----------------------------------------------------------------------------
module scs_div import scs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] num,
	input  logic [VAL_W-1:0] den,
	output logic             done,
	output logic [VAL_W-1:0] res
);

	localparam int CW = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_FIN
	} dstate_t;

	dstate_t          state_q;
	logic [CW-1:0]    cnt_q;
	logic [VAL_W-1:0] mn_q;
	logic [VAL_W-1:0] md_q;
	logic [VAL_W-1:0] r_q;
	logic [VAL_W-1:0] q_q;
	logic             ovf_q;
	logic             neg_q;
	logic [VAL_W-1:0] res_q;
	logic             done_q;
	logic [VAL_W-1:0] r_sh;
	logic             take;

	// shift in the next dividend bit and trial-subtract
	always_comb begin
		r_sh = {r_q[VAL_W-2:0], mn_q[VAL_W-1]};
		take = (r_sh >= md_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						mn_q    <= mag64(num);
						md_q    <= mag64(den);
						neg_q   <= num[VAL_W-1] ^ den[VAL_W-1];
						r_q     <= '0;
						q_q     <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					mn_q <= {mn_q[VAL_W-2:0], 1'b0};
					if (q_q[VAL_W-1]) ovf_q <= 1'b1;
					r_q  <= take ? (r_sh - md_q) : r_sh;
					q_q  <= {q_q[VAL_W-2:0], take};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DIV_STEPS - 1)) state_q <= D_FIN;
				end
				D_FIN: begin
					res_q   <= sat64(q_q, neg_q, ovf_q);
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* hdl/scs_datapath.sv */
// ----------------------------------------------------------------------------
// scs_datapath: stores and arithmetic of the sphere center solver
// Point store, matrix memory, build arithmetic, accumulator, shared units.
// ----------------------------------------------------------------------------
module scs_datapath import scs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  scs_cmd_t                  cmd,
	output scs_sts_t                  sts,
	input  logic signed [COORD_W-1:0] coordinate,
	output logic signed [VAL_W-1:0]   center_coordinate,
	output logic                      last_coordinate,
	output logic                      singular
);

	logic [COORD_W-1:0] ps_mem [DEPTH];
	logic [VAL_W-1:0]   mat_mem [DEPTH];

	logic signed [COORD_W-1:0]   ps_rd_q;
	logic signed [COORD_W-1:0]   b_q;
	logic signed [COORD_W:0]     d_q;
	logic signed [COORD_W:0]     s_q;
	logic signed [2*COORD_W+1:0] prod_q;
	logic [VAL_W-1:0]            rhs_q;
	logic [VAL_W-1:0]            rd_a_q;
	logic [VAL_W-1:0]            rd_b_q;
	logic [VAL_W-1:0]            acc_q;
	logic [VAL_W-1:0]            out_q;
	logic                        last_q;
	logic                        sing_q;

	logic [VAL_W-1:0] coef;
	logic [VAL_W-1:0] wdata;
	logic [VAL_W-1:0] mul_a;
	logic [VAL_W-1:0] div_n;
	logic [VAL_W-1:0] div_d;
	logic [VAL_W-1:0] mul_res;
	logic [VAL_W-1:0] div_res;
	logic             mul_done;
	logic             div_done;

	// point store: write on load, registered read
	always_ff @(posedge clk) begin
		if (cmd.ps_we) ps_mem[cmd.ps_waddr] <= coordinate;
		if (cmd.ps_re) ps_rd_q <= ps_mem[cmd.ps_raddr];
	end

	// matrix memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (cmd.mat_we) mat_mem[cmd.mat_waddr] <= wdata;
		if (cmd.mat_re) begin
			rd_a_q <= mat_mem[cmd.mat_raddr_a];
			rd_b_q <= mat_mem[cmd.mat_raddr_b];
		end
	end

	assign coef = VAL_W'(d_q) << COEF_SHIFT;

	// select matrix write data
	always_comb begin
		case (cmd.mat_wsel)
			WSEL_COEF: wdata = coef;
			WSEL_RHS:  wdata = rhs_q;
			WSEL_RD_A: wdata = rd_a_q;
			WSEL_RD_B: wdata = rd_b_q;
			WSEL_SUB:  wdata = sat_sub64(rd_a_q, mul_res);
			WSEL_ACC:  wdata = acc_q;
			default:   wdata = acc_q;
		endcase
	end

	// build the system: difference, sum, their product (difference of squares), right side
	always_ff @(posedge clk) begin
		if (cmd.b_cap) b_q <= ps_rd_q;
		if (cmd.bld_diff) begin
			d_q <= (COORD_W+1)'(ps_rd_q) - (COORD_W+1)'(b_q);
			s_q <= (COORD_W+1)'(ps_rd_q) + (COORD_W+1)'(b_q);
		end
		if (cmd.bld_mul) prod_q <= d_q * s_q;
		if (cmd.rhs_clr) rhs_q <= '0;
		else if (cmd.rhs_acc) rhs_q <= rhs_q + (VAL_W'(prod_q) << RHS_SHIFT);
	end

	// back substitution accumulator
	always_ff @(posedge clk) begin
		if (cmd.acc_load) acc_q <= rd_a_q;
		else if (cmd.acc_sub) acc_q <= sat_sub64(acc_q, mul_res);
		else if (cmd.acc_div) acc_q <= div_res;
		else if (cmd.acc_zero) acc_q <= '0;
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q  <= cmd.out_sing ? '0 : rd_a_q;
			last_q <= cmd.out_last;
			sing_q <= cmd.out_sing;
		end
	end

	assign mul_a = (cmd.mul_src == SRC_ELIM) ? div_res : rd_a_q;
	assign div_n = (cmd.div_src == SRC_ELIM) ? rd_a_q : acc_q;
	assign div_d = (cmd.div_src == SRC_ELIM) ? rd_b_q : rd_a_q;

	scs_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.b     (rd_b_q),
		.done  (mul_done),
		.res   (mul_res)
	);

	scs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_n),
		.den   (div_d),
		.done  (div_done),
		.res   (div_res)
	);

	assign sts.rd_a_zero = (rd_a_q == '0);
	assign sts.mul_done  = mul_done;
	assign sts.div_done  = div_done;

	assign center_coordinate = out_q;
	assign last_coordinate   = last_q;
	assign singular          = sing_q;

endmodule

/* hdl/scs_ctrl.sv */
// ----------------------------------------------------------------------------
// scs_ctrl: sequencer of the sphere center solver
// Load, build, eliminate with pivot search, back substitute, emit results.
// ----------------------------------------------------------------------------
module scs_ctrl import scs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DIM_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output scs_cmd_t         cmd,
	input  scs_sts_t         sts
);

	typedef enum logic [5:0] {
		ST_LOAD,
		ST_B_RDB, ST_B_RDA, ST_B_DIF, ST_B_MUL, ST_B_ACC, ST_B_RHS,
		ST_P_RD, ST_P_CHK,
		ST_S_RD, ST_S_WI, ST_S_WJ,
		ST_R_CHK, ST_R_RD, ST_R_DIV, ST_R_DWT,
		ST_C_RD, ST_C_MUL, ST_C_MWT, ST_C_WR,
		ST_K_LD, ST_K_ACC, ST_K_CHK, ST_K_RD, ST_K_MUL, ST_K_MWT, ST_K_SUB,
		ST_K_DRD, ST_K_DCK, ST_K_DWT, ST_K_WR,
		ST_O_RD, ST_O_LD, ST_O_WT
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] dim_q;
	logic [AW-1:0]    load_cnt_q;
	logic [AW-1:0]    pa_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] c_q;
	logic             sing_q;
	logic             out_valid_q;

	logic [IDX_W-1:0] n;
	logic [IDX_W-1:0] n_m1;
	logic [AW-1:0]    total_m1;
	logic [AW-1:0]    nn;

	// effective dimension and load geometry
	always_comb begin
		if (dim_q == '0) n = IDX_W'(1);
		else if (32'(dim_q) > MAX_DIM) n = IDX_W'(MAX_DIM);
		else n = IDX_W'(dim_q);
		n_m1     = n - 1'b1;
		total_m1 = AW'((32'(n) + 1) * 32'(n) - 1);
		nn       = AW'(32'(n) * 32'(n));
	end

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;

	// decode commands from state and counters
	always_comb begin
		cmd             = '0;
		cmd.mat_wsel    = WSEL_ACC;
		cmd.div_src     = SRC_ELIM;
		cmd.mul_src     = SRC_ELIM;
		cmd.ps_waddr    = load_cnt_q;
		cmd.out_last    = (i_q == n_m1);
		cmd.out_sing    = sing_q;
		case (state_q)
			ST_LOAD: begin
				cmd.ps_we   = in_valid;
				cmd.rhs_clr = 1'b1;
			end
			ST_B_RDB: begin
				cmd.ps_re    = 1'b1;
				cmd.ps_raddr = nn + AW'(j_q);
			end
			ST_B_RDA: begin
				cmd.b_cap    = 1'b1;
				cmd.ps_re    = 1'b1;
				cmd.ps_raddr = pa_q;
			end
			ST_B_DIF: cmd.bld_diff = 1'b1;
			ST_B_MUL: begin
				cmd.mat_we    = 1'b1;
				cmd.mat_waddr = mat_addr(i_q, j_q);
				cmd.mat_wsel  = WSEL_COEF;
				cmd.bld_mul   = 1'b1;
			end
			ST_B_ACC: cmd.rhs_acc = 1'b1;
			ST_B_RHS: begin
				cmd.mat_we    = 1'b1;
				cmd.mat_waddr = mat_addr(i_q, n);
				cmd.mat_wsel  = WSEL_RHS;
				cmd.rhs_clr   = 1'b1;
			end
			ST_P_RD: begin
				cmd.mat_re      = 1'b1;
				cmd.mat_raddr_a = mat_addr(j_q, i_q);
			end
			ST_S_RD: begin
				cmd.mat_re      = 1'b1;
				cmd.mat_raddr_a = mat_addr(i_q, c_q);
				cmd.mat_raddr_b = mat_addr(j_q, c_q);
			end
			ST_S_WI: begin
				cmd.mat_we    = 1'b1;
				cmd.mat_waddr = mat_addr(i_q, c_q);
				cmd.mat_wsel  = WSEL_RD_B;
			end
			ST_S_WJ: begin
				cmd.mat_we    = 1'b1;
				cmd.mat_waddr = mat_addr(j_q, c_q);
				cmd.mat_wsel  = WSEL_RD_A;
			end
			ST_R_RD: begin
				cmd.mat_re      = 1'b1;
				cmd.mat_raddr_a = mat_addr(k_q, i_q);
				cmd.mat_raddr_b = mat_addr(i_q, i_q);
			end
			ST_R_DIV: cmd.div_start = 1'b1;
			ST_C_RD: begin
				cmd.mat_re      = 1'b1;
				cmd.mat_raddr_a = mat_addr(k_q, c_q);
				cmd.mat_raddr_b = mat_addr(i_q, c_q);
			end
			ST_C_MUL: cmd.mul_start = 1'b1;
			ST_C_WR: begin
				cmd.mat_we    = 1'b1;
				cmd.mat_waddr = mat_addr(k_q, c_q);
				cmd.mat_wsel  = WSEL_SUB;
			end
			ST_K_LD: begin
				cmd.mat_re      = 1'b1;
				cmd.mat_raddr_a = mat_addr(i_q, n);
			end
			ST_K_ACC: cmd.acc_load = 1'b1;
			ST_K_RD: begin
				cmd.mat_re      = 1'b1;
				cmd.mat_raddr_a = mat_addr(i_q, j_q);
				cmd.mat_raddr_b = mat_addr(j_q, n);
			end
			ST_K_MUL: begin
				cmd.mul_start = 1'b1;
				cmd.mul_src   = SRC_BACK;
			end
			ST_K_SUB: cmd.acc_sub = 1'b1;
			ST_K_DRD: begin
				cmd.mat_re      = 1'b1;
				cmd.mat_raddr_a = mat_addr(i_q, i_q);
			end
			ST_K_DCK: begin
				cmd.acc_zero  = sts.rd_a_zero;
				cmd.div_start = !sts.rd_a_zero;
				cmd.div_src   = SRC_BACK;
			end
			ST_K_DWT: begin
				cmd.div_src = SRC_BACK;
				cmd.acc_div = sts.div_done;
			end
			ST_K_WR: begin
				cmd.mat_we    = 1'b1;
				cmd.mat_waddr = mat_addr(i_q, n);
				cmd.mat_wsel  = WSEL_ACC;
			end
			ST_O_RD: begin
				cmd.mat_re      = 1'b1;
				cmd.mat_raddr_a = mat_addr(i_q, n);
			end
			ST_O_LD: cmd.out_load = 1'b1;
			default: cmd.rhs_clr = 1'b0;
		endcase
	end

	// hold state, loop counters and registered flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			dim_q       <= DIM_W'(1);
			load_cnt_q  <= '0;
			pa_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			c_q         <= '0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (load_cnt_q >= total_m1) begin
							load_cnt_q <= '0;
							i_q        <= '0;
							j_q        <= '0;
							pa_q       <= '0;
							sing_q     <= 1'b0;
							state_q    <= ST_B_RDB;
						end else begin
							load_cnt_q <= load_cnt_q + 1'b1;
						end
					end
				end
				ST_B_RDB: state_q <= ST_B_RDA;
				ST_B_RDA: state_q <= ST_B_DIF;
				ST_B_DIF: state_q <= ST_B_MUL;
				ST_B_MUL: state_q <= ST_B_ACC;
				ST_B_ACC: begin
					pa_q <= pa_q + 1'b1;
					if (j_q == n_m1) begin
						state_q <= ST_B_RHS;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_B_RDB;
					end
				end
				ST_B_RHS: begin
					j_q <= '0;
					if (i_q == n_m1) begin
						i_q     <= '0;
						state_q <= ST_P_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_B_RDB;
					end
				end
				// pivot search down the column
				ST_P_RD: state_q <= ST_P_CHK;
				ST_P_CHK: begin
					if (!sts.rd_a_zero) begin
						c_q     <= '0;
						state_q <= ST_S_RD;
					end else if (j_q == n_m1) begin
						sing_q <= 1'b1;
						if (i_q == n_m1) begin
							state_q <= ST_K_LD;
						end else begin
							i_q     <= i_q + 1'b1;
							j_q     <= i_q + 1'b1;
							state_q <= ST_P_RD;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_P_RD;
					end
				end
				// swap pivot row up
				ST_S_RD: state_q <= ST_S_WI;
				ST_S_WI: state_q <= ST_S_WJ;
				ST_S_WJ: begin
					if (c_q == n) begin
						k_q     <= i_q + 1'b1;
						state_q <= ST_R_CHK;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= ST_S_RD;
					end
				end
				ST_R_CHK: begin
					if (k_q == n) begin
						if (i_q == n_m1) begin
							state_q <= ST_K_LD;
						end else begin
							i_q     <= i_q + 1'b1;
							j_q     <= i_q + 1'b1;
							state_q <= ST_P_RD;
						end
					end else begin
						state_q <= ST_R_RD;
					end
				end
				ST_R_RD:  state_q <= ST_R_DIV;
				ST_R_DIV: state_q <= ST_R_DWT;
				ST_R_DWT: begin
					if (sts.div_done) begin
						c_q     <= i_q;
						state_q <= ST_C_RD;
					end
				end
				ST_C_RD:  state_q <= ST_C_MUL;
				ST_C_MUL: state_q <= ST_C_MWT;
				ST_C_MWT: if (sts.mul_done) state_q <= ST_C_WR;
				ST_C_WR: begin
					if (c_q == n) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_R_CHK;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= ST_C_RD;
					end
				end
				// back substitution, last row first
				ST_K_LD: state_q <= ST_K_ACC;
				ST_K_ACC: begin
					j_q     <= i_q + 1'b1;
					state_q <= ST_K_CHK;
				end
				ST_K_CHK: state_q <= (j_q == n) ? ST_K_DRD : ST_K_RD;
				ST_K_RD:  state_q <= ST_K_MUL;
				ST_K_MUL: state_q <= ST_K_MWT;
				ST_K_MWT: if (sts.mul_done) state_q <= ST_K_SUB;
				ST_K_SUB: begin
					j_q     <= j_q + 1'b1;
					state_q <= ST_K_CHK;
				end
				ST_K_DRD: state_q <= ST_K_DCK;
				ST_K_DCK: begin
					if (sts.rd_a_zero) begin
						sing_q  <= 1'b1;
						state_q <= ST_K_WR;
					end else begin
						state_q <= ST_K_DWT;
					end
				end
				ST_K_DWT: if (sts.div_done) state_q <= ST_K_WR;
				ST_K_WR: begin
					if (i_q == '0) begin
						state_q <= ST_O_RD;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= ST_K_LD;
					end
				end
				// emit one word per center coordinate
				ST_O_RD: state_q <= ST_O_LD;
				ST_O_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_O_WT;
				end
				ST_O_WT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (i_q == n_m1) begin
							state_q <= ST_LOAD;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_O_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
			if (cfg_we) begin
				dim_q      <= cfg_wdata;
				load_cnt_q <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result word is pending");

	a_last_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && (i_q == n_m1)) |=> in_ready)
		else $error("no return to loading after the final word");

	a_cfg_clears_load: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (load_cnt_q == '0))
		else $error("dimension write did not drop the partial load");
`endif

endmodule
